>>> hw/rtl/decimal_csv_row_parser_top_assert.svh
// Assertion macros shared by the parser modules.
`ifndef DECIMAL_CSV_ROW_PARSER_TOP_ASSERT_SVH
`define DECIMAL_CSV_ROW_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DCSV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dcsv assertion failed");
`define DCSV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("dcsv assertion failed");
`else
`define DCSV_ASSERT(label, prop)
`define DCSV_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hw/rtl/dcsv_pkg.sv
`default_nettype none
package dcsv_pkg;

  localparam int unsigned MaxCells = 1048576;
  localparam int unsigned CellW = 16;
  localparam int unsigned CountW = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = 2;
  localparam int unsigned QueueCntW = 3;

  localparam logic [7:0] ChComma = 8'd44;
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChZero = 8'd48;
  localparam logic [7:0] ChNine = 8'd57;
  localparam logic [CellW-1:0] CellMax = 16'hFFFF;

  // One field or row boundary, handed from the byte front end to the emitter.
  typedef struct packed {
    logic              is_newline;
    logic              has_field;
    logic [CellW-1:0]  value;
  } q_entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/dcsv_front.sv
`default_nettype none
module dcsv_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output dcsv_pkg::q_entry_t    q_wdata
);
  import dcsv_pkg::*;

  logic [CellW-1:0] field_accum;
  logic [CellW-1:0] field_accum_next;
  logic             field_valid;
  logic             field_valid_next;
  logic             field_has_bytes;
  logic             field_has_bytes_next;

  logic        accept;
  logic        is_comma;
  logic        is_newline;
  logic        is_digit;
  logic [19:0] times_ten;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign is_comma   = (ch == ChComma);
  assign is_newline = (ch == ChNewline);
  assign is_digit   = (ch >= ChZero) && (ch <= ChNine);

  // value * 10 + digit as shift-and-add; the widest result stays below 2^20.
  assign times_ten = {1'b0, field_accum, 3'b000} + {3'b000, field_accum, 1'b0}
                   + {16'd0, 4'(ch - ChZero)};

  assign q_push             = accept && (is_comma || is_newline);
  assign q_wdata.is_newline = is_newline;
  assign q_wdata.has_field  = is_comma || field_has_bytes;
  assign q_wdata.value      = field_valid ? field_accum : CellMax;

  always_comb begin
    field_accum_next     = field_accum;
    field_valid_next     = field_valid;
    field_has_bytes_next = field_has_bytes;
    if (accept) begin
      if (is_comma || is_newline) begin
        field_accum_next     = '0;
        field_valid_next     = 1'b1;
        field_has_bytes_next = 1'b0;
      end else begin
        field_has_bytes_next = 1'b1;
        if (!is_digit) begin
          field_valid_next = 1'b0;
        end else if (field_valid) begin
          field_accum_next = (times_ten > 20'({CellMax})) ? CellMax : times_ten[CellW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_accum     <= '0;
      field_valid     <= 1'b1;
      field_has_bytes <= 1'b0;
    end else begin
      field_accum     <= field_accum_next;
      field_valid     <= field_valid_next;
      field_has_bytes <= field_has_bytes_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dcsv_queue.sv
`default_nettype none
`include "decimal_csv_row_parser_top_assert.svh"
module dcsv_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire dcsv_pkg::q_entry_t wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output dcsv_pkg::q_entry_t    head
);
  import dcsv_pkg::*;

  q_entry_t               entries [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCntW-1:0]   count;
  logic [QueueCntW-1:0]   count_next;

  assign full       = (count == QueueCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  `DCSV_ASSERT(a_no_pop_when_empty, pop |-> head_valid)
  `DCSV_ASSERT(a_no_push_when_full, push |-> !full)
  `DCSV_ASSERT(a_count_tracks, (push && !pop) |=> (count == $past(count) + 1'b1))

endmodule
`default_nettype wire

>>> hw/rtl/dcsv_back.sv
`default_nettype none
`include "decimal_csv_row_parser_top_assert.svh"
module dcsv_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dcsv_pkg::CountW-1:0]    cfg_wdata,
  input  wire logic                           head_valid,
  input  wire dcsv_pkg::q_entry_t             head,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dcsv_pkg::CellW-1:0]          cell_value,
  output logic [dcsv_pkg::CountW-1:0]         run_length,
  output logic                                row_end
);
  import dcsv_pkg::*;

  logic [CountW-1:0] limit;
  logic [CountW-1:0] cells_emitted;
  logic [CountW-1:0] cells_emitted_next;
  logic              phase;
  logic              phase_next;
  logic              out_valid_next;

  logic              can_load;
  logic              room;
  logic              load;
  logic              load_pad;
  logic [CellW-1:0]  load_value;
  logic [CountW-1:0] left;

  assign can_load = !out_valid || out_ready;
  assign room     = (cells_emitted < limit);
  assign left     = room ? (limit - cells_emitted) : '0;

  // A newline that closes a field takes two output slots while the row has room: the field, then the padding run.
  always_comb begin
    pop                = 1'b0;
    load               = 1'b0;
    load_pad           = 1'b0;
    load_value         = head.value;
    cells_emitted_next = cells_emitted;
    phase_next         = phase;
    if (head_valid && can_load) begin
      if (!head.is_newline) begin
        pop = 1'b1;
        if (room) begin
          load               = 1'b1;
          cells_emitted_next = cells_emitted + 1'b1;
        end
      end else if (!phase && head.has_field && room) begin
        load               = 1'b1;
        cells_emitted_next = cells_emitted + 1'b1;
        phase_next         = 1'b1;
      end else begin
        pop                = 1'b1;
        load               = 1'b1;
        load_pad           = 1'b1;
        load_value         = CellMax;
        cells_emitted_next = '0;
        phase_next         = 1'b0;
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit         <= CountW'(1);
      cells_emitted <= '0;
      phase         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          limit <= CountW'(1);
        end else if (cfg_wdata > CountW'(MaxCells)) begin
          limit <= CountW'(MaxCells);
        end else begin
          limit <= cfg_wdata;
        end
      end
      cells_emitted <= cells_emitted_next;
      phase         <= phase_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cell_value <= load_value;
      run_length <= load_pad ? left : CountW'(1);
      row_end    <= load_pad;
    end
  end

  `DCSV_ASSERT(a_phase_on_newline, phase |-> (head_valid && head.is_newline && head.has_field))
  `DCSV_ASSERT(a_pad_clears_count, (load && load_pad) |=> (cells_emitted == '0 && !phase))
  `DCSV_ASSERT_ALWAYS(a_limit_in_range, rst || (limit != '0 && limit <= CountW'(MaxCells)))

endmodule
`default_nettype wire

>>> hw/rtl/decimal_csv_row_parser_top.sv
`default_nettype none
// Decimal CSV row parser.
// Input channel (in_valid/in_ready, ch) takes one text byte per transaction.
// Digits build a field, a comma closes it, byte 10 closes the field and the row.
// Output channel (out_valid/out_ready) gives cell_value, run_length and row_end:
// one transaction per closed field (run_length 1), and one padding transaction
// with row_end set at every newline, whose run_length counts the cells still
// missing from the row (value 65535). Fields past cells_per_row are dropped.
// cfg_we/cfg_wdata write cells_per_row; 0 acts as 1, values above 1048576 clamp.
// Throughput: one byte per cycle while the queue is not full. A separator accepted
// is written into the queue, then loaded from the queue head into the output
// registers; a newline closing a field gives its two results one after the
// other, field first. A four-entry queue sits between the byte front end and
// the output emitter, so bytes keep flowing while the receiver stalls until that
// queue fills; in_ready drops only when it is full.
// Reset clears the open field, the cell count and the queue, and sets
// cells_per_row to 1.
module decimal_csv_row_parser_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     ch,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dcsv_pkg::CellW-1:0]          cell_value,
  output logic [dcsv_pkg::CountW-1:0]         run_length,
  output logic                                row_end,
  input  wire logic                           cfg_we,
  input  wire logic [dcsv_pkg::CountW-1:0]    cfg_wdata
);
  import dcsv_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_wdata;
  q_entry_t q_head;

  dcsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  dcsv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  dcsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .run_length (run_length),
    .row_end    (row_end)
  );

endmodule
`default_nettype wire
